/* design/kmrg_pkg.sv */
package kmrg_pkg;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_FETCH  = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	localparam logic [1:0] CFG_NUM_ARRAYS  = 2'd0;
	localparam logic [1:0] CFG_ARRAY_LEN   = 2'd1;
	localparam logic [1:0] CFG_MERGE_ORDER = 2'd2;

	localparam int CMP_W = 18;

	typedef struct packed {
		logic restart;
		logic load;
		logic fetch;
		logic setup;
		logic qfill;
		logic qrd;
		logic pop1;
		logic pop2;
		logic seq_init;
		logic mrd;
		logic mstep;
		logic crd;
		logic cwr;
		logic after;
	} cmd_t;

	typedef struct packed {
		logic total_ok;
		logic one_total;
		logic load_last;
		logic fetch_last;
		logic balanced;
		logic multi_run;
		logic fill_last;
		logic merge_last;
		logic copy_last;
		logic more;
	} stat_t;

endpackage

/* design/kmrg_ctrl.sv */
module kmrg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             mode,
	input  logic             cfg_hit,
	input  kmrg_pkg::stat_t  stat,
	output kmrg_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             res_valid_s1,
	output kmrg_pkg::kind_t  res_kind_s1,
	output logic             res_last_s1
);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_SETUP = 13'b0000000000010,
		S_QFILL = 13'b0000000000100,
		S_POP1  = 13'b0000000001000,
		S_POP1W = 13'b0000000010000,
		S_POP2  = 13'b0000000100000,
		S_POP2W = 13'b0000001000000,
		S_SEQ   = 13'b0000010000000,
		S_MRD   = 13'b0000100000000,
		S_MCMP  = 13'b0001000000000,
		S_CRD   = 13'b0010000000000,
		S_CWR   = 13'b0100000000000,
		S_NEXT  = 13'b1000000000000
	} state_t;

	typedef enum logic [1:0] {
		PH_LOADING = 2'd0,
		PH_READY   = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic accept, load_done;
	kmrg_pkg::kind_t kind_d;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		phase_d   = phase_q;
		kind_d    = kmrg_pkg::KIND_REJECT;
		load_done = 1'b0;
		if (accept && stat.total_ok) begin
			if (!mode) begin
				if (phase_q == PH_DONE || phase_q == PH_LOADING) begin
					cmd.restart = (phase_q == PH_DONE);
					cmd.load    = 1'b1;
					kind_d      = kmrg_pkg::KIND_LOAD;
					load_done   = (phase_q == PH_DONE) ? stat.one_total : stat.load_last;
					phase_d     = load_done ? PH_READY : PH_LOADING;
				end
			end else if (phase_q == PH_READY) begin
				cmd.fetch = 1'b1;
				kind_d    = kmrg_pkg::KIND_FETCH;
				if (stat.fetch_last) phase_d = PH_DONE;
			end
		end
		if (cfg_hit) begin
			cmd.restart = 1'b1;
			phase_d     = PH_LOADING;
		end
		case (state_q)
			S_IDLE: begin
				if (load_done) state_d = S_SETUP;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				if (!stat.multi_run) state_d = S_IDLE;
				else if (stat.balanced) state_d = S_QFILL;
				else state_d = S_SEQ;
			end
			S_QFILL: begin
				cmd.qfill = 1'b1;
				if (stat.fill_last) state_d = S_POP1;
			end
			S_POP1: begin
				cmd.qrd = 1'b1;
				state_d = S_POP1W;
			end
			S_POP1W: begin
				cmd.pop1 = 1'b1;
				state_d  = S_POP2;
			end
			S_POP2: begin
				cmd.qrd = 1'b1;
				state_d = S_POP2W;
			end
			S_POP2W: begin
				cmd.pop2 = 1'b1;
				state_d  = S_MRD;
			end
			S_SEQ: begin
				cmd.seq_init = 1'b1;
				state_d      = S_MRD;
			end
			S_MRD: begin
				cmd.mrd = 1'b1;
				state_d = S_MCMP;
			end
			S_MCMP: begin
				cmd.mstep = 1'b1;
				state_d   = stat.merge_last ? S_CRD : S_MRD;
			end
			S_CRD: begin
				cmd.crd = 1'b1;
				state_d = S_CWR;
			end
			S_CWR: begin
				cmd.cwr = 1'b1;
				state_d = stat.copy_last ? S_NEXT : S_CRD;
			end
			S_NEXT: begin
				cmd.after = 1'b1;
				if (!stat.more) state_d = S_IDLE;
				else if (stat.balanced) state_d = S_POP1;
				else state_d = S_SEQ;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_LOADING;
			res_valid_s1 <= 1'b0;
			res_kind_s1  <= kmrg_pkg::KIND_REJECT;
			res_last_s1  <= 1'b0;
		end else begin
			state_q      <= state_d;
			phase_q      <= phase_d;
			res_valid_s1 <= accept;
			res_kind_s1  <= kind_d;
			res_last_s1  <= cmd.fetch && stat.fetch_last;
		end
	end

endmodule

/* design/kmrg_dp.sv */
module kmrg_dp #(
	parameter int MAX_TOTAL  = 4096,
	parameter int MAX_RUNS   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  kmrg_pkg::cmd_t                     cmd,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [10:0]                        cfg_data,
	input  logic signed [31:0]                 value,
	output kmrg_pkg::stat_t                    stat,
	output logic signed [DATA_WIDTH-1:0]       rd_a_q,
	output logic [kmrg_pkg::CMP_W-1:0]         cmp_q
);

	localparam int AW = $clog2(MAX_TOTAL);
	localparam int LW = $clog2(MAX_TOTAL + 1);
	localparam int QW = $clog2(MAX_RUNS);
	localparam int CW = $clog2(MAX_RUNS + 1);
	localparam logic [kmrg_pkg::CMP_W-1:0] CMP_MAX = '1;

	logic signed [DATA_WIDTH-1:0] mem_a [MAX_TOTAL];
	logic signed [DATA_WIDTH-1:0] mem_b [MAX_TOTAL];
	logic [AW-1:0] q_start [MAX_RUNS];
	logic [LW-1:0] q_len [MAX_RUNS];

	logic [6:0]  num_arrays_q;
	logic [10:0] array_len_q;
	logic        merge_order_q;

	logic [LW-1:0] load_count_q, fetch_count_q;
	logic [AW-1:0] sa_q, sb_q, dst_q, tail_q, res_start_q;
	logic [LW-1:0] na_q, nb_q, i_q, j_q, k_q, t_q, rl_q, fill_start_q;
	logic [6:0]    idx_q, fill_cnt_q;
	logic [QW-1:0] qh_q, qt_q;
	logic [CW-1:0] qc_q;
	logic signed [DATA_WIDTH-1:0] rd_b_q, rd_bb_q;
	logic [AW-1:0] qs_rd_q;
	logic [LW-1:0] ql_rd_q;

	logic [17:0]   prod;
	logic [LW-1:0] total, n, len, lc_eff;
	logic [AW-1:0] addr_a, addr_b, waddr_a;
	logic          we_a, q_we, a_done, b_done, take_x;
	logic signed [DATA_WIDTH-1:0] wdata_a;
	logic [AW-1:0] q_wstart;
	logic [LW-1:0] q_wlen;

	function automatic logic [AW-1:0] wrap(input logic [LW:0] s);
		if (s >= (LW+1)'(MAX_TOTAL)) return AW'(s - (LW+1)'(MAX_TOTAL));
		return AW'(s);
	endfunction

	function automatic logic [QW-1:0] qinc(input logic [QW-1:0] p);
		if (p == QW'(MAX_RUNS - 1)) return '0;
		return p + 1'b1;
	endfunction

	assign prod   = 18'(num_arrays_q) * 18'(array_len_q);
	assign total  = LW'(prod);
	assign n      = LW'(array_len_q);
	assign len    = LW'({1'b0, na_q} + {1'b0, nb_q});
	assign lc_eff = cmd.restart ? '0 : load_count_q;
	assign a_done = (i_q >= na_q);
	assign b_done = (j_q >= nb_q);
	assign take_x = b_done || (!a_done && (rd_a_q <= rd_b_q));

	always_comb begin
		stat.total_ok   = (num_arrays_q != '0) && (32'(num_arrays_q) <= MAX_RUNS)
			&& (array_len_q != '0) && (32'(prod) <= MAX_TOTAL);
		stat.one_total  = (total == LW'(1));
		stat.load_last  = (load_count_q == total - 1'b1);
		stat.fetch_last = (fetch_count_q == total - 1'b1);
		stat.balanced   = merge_order_q;
		stat.multi_run  = (num_arrays_q > 7'd1);
		stat.fill_last  = (fill_cnt_q == num_arrays_q - 7'd1);
		stat.merge_last = ({1'b0, k_q} == {1'b0, na_q} + {1'b0, nb_q} - 1'b1);
		stat.copy_last  = (t_q == len - 1'b1);
		stat.more       = merge_order_q ? (qc_q != '0)
			: ({1'b0, idx_q} + 8'd1 < {1'b0, num_arrays_q});
	end

	always_comb begin
		addr_a = cmd.fetch ? wrap({1'b0, LW'(res_start_q)} + {1'b0, fetch_count_q})
			: wrap({1'b0, LW'(sa_q)} + {1'b0, i_q});
		addr_b = wrap({1'b0, LW'(sb_q)} + {1'b0, j_q});
		we_a    = cmd.load || cmd.cwr;
		waddr_a = cmd.load ? AW'(lc_eff) : wrap({1'b0, LW'(dst_q)} + {1'b0, t_q});
		wdata_a = cmd.load ? DATA_WIDTH'(value) : rd_bb_q;
		q_we     = cmd.qfill || (cmd.after && merge_order_q);
		q_wstart = cmd.qfill ? AW'(fill_start_q) : dst_q;
		q_wlen   = cmd.qfill ? n : len;
	end

	always_ff @(posedge clk) begin
		if (we_a) mem_a[waddr_a] <= wdata_a;
		rd_a_q <= mem_a[addr_a];
		rd_b_q <= mem_a[addr_b];
		if (cmd.mstep) mem_b[AW'(k_q)] <= take_x ? rd_a_q : rd_b_q;
		rd_bb_q <= mem_b[AW'(t_q)];
		if (q_we) begin
			q_start[qt_q] <= q_wstart;
			q_len[qt_q]   <= q_wlen;
		end
		qs_rd_q <= q_start[qh_q];
		ql_rd_q <= q_len[qh_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_arrays_q  <= 7'd2;
			array_len_q   <= 11'd1;
			merge_order_q <= 1'b1;
			load_count_q  <= '0;
			fetch_count_q <= '0;
			cmp_q         <= '0;
			sa_q <= '0; sb_q <= '0; na_q <= '0; nb_q <= '0;
			i_q <= '0; j_q <= '0; k_q <= '0; t_q <= '0;
			dst_q <= '0; tail_q <= '0; res_start_q <= '0; rl_q <= '0;
			idx_q <= '0; fill_cnt_q <= '0; fill_start_q <= '0;
			qh_q <= '0; qt_q <= '0; qc_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kmrg_pkg::CFG_NUM_ARRAYS:  num_arrays_q  <= cfg_data[6:0];
					kmrg_pkg::CFG_ARRAY_LEN:   array_len_q   <= cfg_data;
					kmrg_pkg::CFG_MERGE_ORDER: merge_order_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.restart) begin
				load_count_q  <= '0;
				fetch_count_q <= '0;
				cmp_q         <= '0;
				res_start_q   <= '0;
			end
			if (cmd.load) load_count_q <= lc_eff + 1'b1;
			if (cmd.fetch) fetch_count_q <= fetch_count_q + 1'b1;
			if (cmd.setup) begin
				qh_q <= '0; qt_q <= '0; qc_q <= '0;
				tail_q       <= (total == LW'(MAX_TOTAL)) ? '0 : AW'(total);
				fill_start_q <= '0;
				fill_cnt_q   <= '0;
				rl_q         <= n;
				idx_q        <= 7'd1;
				res_start_q  <= '0;
			end
			if (cmd.qfill) begin
				qt_q         <= qinc(qt_q);
				qc_q         <= qc_q + 1'b1;
				fill_start_q <= fill_start_q + n;
				fill_cnt_q   <= fill_cnt_q + 7'd1;
			end
			// the queue head advances on the first read so the second read sees the next run
			if (cmd.pop1) begin
				sa_q <= qs_rd_q;
				na_q <= ql_rd_q;
				qh_q <= qinc(qh_q);
				qc_q <= qc_q - 1'b1;
			end
			if (cmd.pop2) begin
				sb_q  <= qs_rd_q;
				nb_q  <= ql_rd_q;
				qh_q  <= qinc(qh_q);
				qc_q  <= qc_q - 1'b1;
				dst_q <= tail_q;
				i_q <= '0; j_q <= '0; k_q <= '0; t_q <= '0;
			end
			if (cmd.seq_init) begin
				sa_q  <= '0;
				na_q  <= rl_q;
				sb_q  <= AW'(rl_q);
				nb_q  <= n;
				dst_q <= '0;
				i_q <= '0; j_q <= '0; k_q <= '0; t_q <= '0;
			end
			if (cmd.mstep) begin
				k_q <= k_q + 1'b1;
				if (take_x) i_q <= i_q + 1'b1;
				else j_q <= j_q + 1'b1;
				if (!a_done && !b_done && cmp_q != CMP_MAX) cmp_q <= cmp_q + 1'b1;
			end
			if (cmd.cwr) t_q <= t_q + 1'b1;
			if (cmd.after) begin
				if (merge_order_q) begin
					qt_q        <= qinc(qt_q);
					qc_q        <= qc_q + 1'b1;
					tail_q      <= wrap({1'b0, LW'(tail_q)} + {1'b0, len});
					res_start_q <= dst_q;
				end else begin
					rl_q  <= rl_q + n;
					idx_q <= idx_q + 7'd1;
				end
			end
		end
	end

endmodule

/* design/k_way_sorted_run_merger_top.sv */
// K-way merger of sorted runs. Load num_arrays*array_len values (mode 0) in run order, then
// fetch the merged sequence (mode 1); every accepted item gives one result, strobed on done
// for one cycle in the cycle after the transfer, and the receiver cannot stall it. The last load
// raises busy while a two-way merge engine works on the single-port-write value store: each
// merge reads and compares the heads of its two runs and stores the smaller, then copies the
// merged run back; sequential order merges each run into the growing running result, and
// balanced order fills a run queue with all k runs, then merges pairs from it and queues each
// result. Configuration is taken whenever busy is low.
module k_way_sorted_run_merger_top #(
	parameter int MAX_TOTAL  = 4096,
	parameter int MAX_RUNS   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       mode,
	input  logic signed [31:0]         value,
	output logic                       done,
	output logic [1:0]                 kind,
	output logic signed [31:0]         merged_value,
	output logic                       last,
	output logic [17:0]                comparisons,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [10:0]                cfg_data
);

	kmrg_pkg::cmd_t  cmd;
	kmrg_pkg::stat_t stat;
	kmrg_pkg::kind_t res_kind_s1;
	logic res_valid_s1, res_last_s1, cfg_fire, cfg_hit;
	logic signed [DATA_WIDTH-1:0] rd_a_q;
	logic [kmrg_pkg::CMP_W-1:0] cmp_q;

	assign cfg_ready = !busy;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_fire && (cfg_index == kmrg_pkg::CFG_NUM_ARRAYS
		|| cfg_index == kmrg_pkg::CFG_ARRAY_LEN || cfg_index == kmrg_pkg::CFG_MERGE_ORDER);

	kmrg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.mode         (mode),
		.cfg_hit      (cfg_hit),
		.stat         (stat),
		.cmd          (cmd),
		.busy         (busy),
		.res_valid_s1 (res_valid_s1),
		.res_kind_s1  (res_kind_s1),
		.res_last_s1  (res_last_s1)
	);

	kmrg_dp #(
		.MAX_TOTAL  (MAX_TOTAL),
		.MAX_RUNS   (MAX_RUNS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_fire),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.value     (value),
		.stat      (stat),
		.rd_a_q    (rd_a_q),
		.cmp_q     (cmp_q)
	);

	assign done         = res_valid_s1;
	assign kind         = res_kind_s1;
	assign merged_value = (res_kind_s1 == kmrg_pkg::KIND_FETCH) ? 32'(rd_a_q) : 32'sd0;
	assign last         = res_last_s1;
	assign comparisons  = res_last_s1 ? cmp_q : 18'd0;

`ifndef ASSERT_OFF
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("accepted item gave no result");
	a_last_is_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> done && kind == kmrg_pkg::KIND_FETCH)
		else $error("last flag outside a fetch result");
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && !$past(mode))
		else $error("merge started without a load");
	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start) && !$past(busy))
		else $error("result without an accepted item");
`endif

endmodule
